[rtl/core/first_fit_page_allocator_macros.svh]
// assertion macros for the page allocator
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define FFPA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FFPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ffpa_pkg.sv]
package ffpa_pkg;

  // sizing of the pool and tag space
  localparam int unsigned NUM_PAGES  = 256;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned TAG_COUNT  = 8;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  // port field widths
  localparam int unsigned OP_W     = 1;
  localparam int unsigned BYTES_W  = 32;
  localparam int unsigned TAG_W    = 3;
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned FREED_W  = 32;
  localparam int unsigned POOL_W   = 9;

  // internal widths
  localparam int unsigned PIDX_W = $clog2(NUM_PAGES);
  localparam int unsigned PCNT_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned TIDX_W = $clog2(TAG_COUNT);
  localparam int unsigned NEED_W = BYTES_W + 1 - PAGE_SHIFT;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned META_W = PCNT_W + TIDX_W;

  localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(256);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_START = 2'd2;

  // page map entry codes
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONT  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic mark_step;
    logic free_init;
    logic clr_step;
    logic fail_alloc;
    logic fail_free;
  } ffpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_free;
    logic need_ok;
    logic scan_hit;
    logic scan_last;
    logic mark_last;
    logic is_start;
    logic clr_last;
  } ffpa_sts_t;

endpackage

[rtl/core/ffpa_ram.sv]
module ffpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/ffpa_ctrl.sv]
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output ffpa_cmd_t cmd_o,
  input  ffpa_sts_t sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MARK   = 3'd3;
  localparam logic [2:0] S_FLOOK  = 3'd4;
  localparam logic [2:0] S_FCLR   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a new request may be taken while idle or while a result is shown
  assign busy_o = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign done_o = (state_q == S_DONE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q) inside
      S_IDLE, S_DONE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DECODE: begin
        if (sts_i.op_free) begin
          state_d = S_FLOOK;
        end else if (sts_i.need_ok) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.fail_alloc = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_MARK;
        end else if (sts_i.scan_last) begin
          cmd_o.fail_alloc = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_last) begin
          state_d = S_DONE;
        end
      end
      S_FLOOK: begin
        if (sts_i.is_start) begin
          cmd_o.free_init = 1'b1;
          state_d         = S_FCLR;
        end else begin
          cmd_o.fail_free = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_FCLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ffpa_datapath.sv]
module ffpa_datapath import ffpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffpa_cmd_t           cmd_i,
  output ffpa_sts_t           sts_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [BYTES_W-1:0]  request_bytes_i,
  input  logic [TAG_W-1:0]    owner_tag_i,
  input  logic [PAGE_W-1:0]   free_start_i,
  input  logic                cfg_we_i,
  input  logic [POOL_W-1:0]   cfg_data_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [PAGE_W-1:0]   start_page_o,
  output logic [CNT_W-1:0]    run_pages_o,
  output logic [CNT_W-1:0]    in_use_pages_o,
  output logic [CNT_W-1:0]    peak_in_use_o,
  output logic [FREED_W-1:0]  freed_total_o,
  output logic [CNT_W-1:0]    tag_in_use_o
);

  // configuration and latched request
  logic [POOL_W-1:0]   pool_q;
  logic [OP_W-1:0]     op_q;
  logic [NEED_W-1:0]   need_q;
  logic [TIDX_W-1:0]   tag_q;
  logic [PAGE_W-1:0]   fstart_q;

  // scan and sweep state
  logic [PCNT_W-1:0]   iss_q, chk_q, run_q, k_q, fn_q;
  logic [PIDX_W-1:0]   first_q;
  logic [TIDX_W-1:0]   ft_q;

  // result and counters
  logic [STATUS_W-1:0] status_q;
  logic [PIDX_W-1:0]   start_q;
  logic [PCNT_W-1:0]   count_q;
  logic [PCNT_W-1:0]   tag_pages_q [TAG_COUNT];
  logic [PCNT_W-1:0]   tag_pages_d [TAG_COUNT];
  logic [PCNT_W-1:0]   used_q, peak_q;
  logic [FREED_W-1:0]  released_q;

  // page map valid flops
  logic [NUM_PAGES-1:0] kvld_q;
  logic                 kvld_rd_q;

  logic [BYTES_W:0]    bytes_sum;
  logic [NEED_W-1:0]   need_in;
  logic [PCNT_W-1:0]   lim;
  logic [PCNT_W-1:0]   need_cnt;
  logic [PIDX_W-1:0]   rd_addr;
  logic [KIND_W-1:0]   kind_ram_rd, kind_rd, kind_wdata;
  logic [META_W-1:0]   meta_rd, meta_wdata;
  logic                kind_we, meta_we;
  logic [PCNT_W-1:0]   wbase, wsum;
  logic [PIDX_W-1:0]   waddr;
  logic [PCNT_W-1:0]   run_inc, k_inc;
  logic                free_pg, in_range;
  logic                alloc_commit, free_commit;
  logic [PCNT_W-1:0]   used_add;
  logic [FREED_W:0]    rel_sum;

  // pages needed: round up to whole pages, zero bytes takes one page
  assign bytes_sum = {1'b0, request_bytes_i} + (BYTES_W + 1)'(PAGE_BYTES - 1);
  assign need_in   = (request_bytes_i == '0) ? NEED_W'(1) : bytes_sum[BYTES_W:PAGE_SHIFT];

  // effective pool size
  always_comb begin
    if (32'(pool_q) > NUM_PAGES) begin
      lim = PCNT_W'(NUM_PAGES);
    end else begin
      lim = PCNT_W'(pool_q);
    end
  end

  assign need_cnt = need_q[PCNT_W-1:0];

  // page map read address: scan pointer or the page to free
  always_comb begin
    if (cmd_i.scan_step) begin
      rd_addr = iss_q[PIDX_W-1:0];
    end else if (op_q == OP_FREE) begin
      rd_addr = PIDX_W'(fstart_q);
    end else begin
      rd_addr = '0;
    end
  end

  // page map write: mark a new run or clear a freed one
  assign wbase      = cmd_i.mark_step ? {1'b0, first_q} : PCNT_W'(fstart_q);
  assign wsum       = wbase + k_q;
  assign waddr      = wsum[PIDX_W-1:0];
  assign kind_we    = cmd_i.mark_step || cmd_i.clr_step;
  assign kind_wdata = cmd_i.clr_step ? KIND_FREE : ((k_q == '0) ? KIND_START : KIND_CONT);
  assign meta_we    = cmd_i.mark_step && (k_q == '0);
  assign meta_wdata = {need_cnt, tag_q};

  ffpa_ram #(
    .WIDTH(KIND_W),
    .DEPTH(NUM_PAGES)
  ) u_kind_ram (
    .clk_i  (clk_i),
    .we_i   (kind_we),
    .waddr_i(waddr),
    .wdata_i(kind_wdata),
    .raddr_i(rd_addr),
    .rdata_o(kind_ram_rd)
  );

  ffpa_ram #(
    .WIDTH(META_W),
    .DEPTH(NUM_PAGES)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(waddr),
    .wdata_i(meta_wdata),
    .raddr_i(rd_addr),
    .rdata_o(meta_rd)
  );

  // a page never written reads as free
  assign kind_rd = kvld_rd_q ? kind_ram_rd : KIND_FREE;

  // scan and sweep status
  assign free_pg  = (kind_rd == KIND_FREE);
  assign run_inc  = run_q + PCNT_W'(1);
  assign k_inc    = k_q + PCNT_W'(1);
  assign in_range = (32'(fstart_q) < NUM_PAGES);

  assign sts_o.op_free   = (op_q == OP_FREE);
  assign sts_o.need_ok   = (need_q <= NEED_W'(lim));
  assign sts_o.scan_hit  = free_pg && (NEED_W'(run_inc) >= need_q);
  assign sts_o.scan_last = (chk_q == (lim - PCNT_W'(1)));
  assign sts_o.mark_last = (k_inc == need_cnt);
  assign sts_o.is_start  = in_range && (kind_rd == KIND_START);
  assign sts_o.clr_last  = (k_inc >= fn_q) ||
                           ((32'(fstart_q) + 32'(k_q) + 1) >= NUM_PAGES);

  assign alloc_commit = cmd_i.mark_step && sts_o.mark_last;
  assign free_commit  = cmd_i.clr_step && sts_o.clr_last;

  assign used_add = used_q + need_cnt;
  assign rel_sum  = {1'b0, released_q} + (FREED_W + 1)'(fn_q);

  // per-tag counters, each entry updates on its own match
  always_comb begin
    for (int i = 0; i < TAG_COUNT; i++) begin
      tag_pages_d[i] = tag_pages_q[i];
      if (alloc_commit && (tag_q == TIDX_W'(i))) begin
        tag_pages_d[i] = tag_pages_q[i] + need_cnt;
      end
      if (free_commit && (ft_q == TIDX_W'(i))) begin
        tag_pages_d[i] = (tag_pages_q[i] > fn_q) ? (tag_pages_q[i] - fn_q) : '0;
      end
    end
  end

  // pool size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= POOL_RESET;
    end else if (cfg_we_i) begin
      pool_q <= cfg_data_i;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      need_q   <= need_in;
      tag_q    <= TIDX_W'(owner_tag_i);
      fstart_q <= free_start_i;
    end
  end

  // scan pointers, run tracking and sweep counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      iss_q <= PCNT_W'(1);
      chk_q <= '0;
      run_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.scan_step) begin
        iss_q <= iss_q + PCNT_W'(1);
        chk_q <= chk_q + PCNT_W'(1);
        run_q <= free_pg ? run_inc : '0;
        if (free_pg && (run_q == '0)) begin
          first_q <= chk_q[PIDX_W-1:0];
        end
      end
      if (cmd_i.mark_step || cmd_i.clr_step) begin
        k_q <= k_inc;
      end
    end
    if (cmd_i.free_init) begin
      fn_q <= meta_rd[META_W-1:TIDX_W];
      ft_q <= meta_rd[TIDX_W-1:0];
    end
  end

  // result fields of the current transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.fail_alloc) begin
      status_q <= ST_NO_RUN;
      start_q  <= '0;
      count_q  <= '0;
    end else if (cmd_i.fail_free) begin
      status_q <= ST_NOT_START;
      start_q  <= PIDX_W'(fstart_q);
      count_q  <= '0;
    end else if (alloc_commit) begin
      status_q <= ST_OK;
      start_q  <= first_q;
      count_q  <= need_cnt;
    end else if (free_commit) begin
      status_q <= ST_OK;
      start_q  <= PIDX_W'(fstart_q);
      count_q  <= fn_q;
    end
  end

  // usage counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAG_COUNT; i++) begin
        tag_pages_q[i] <= '0;
      end
      used_q     <= '0;
      peak_q     <= '0;
      released_q <= '0;
    end else begin
      tag_pages_q <= tag_pages_d;
      if (alloc_commit) begin
        used_q <= used_add;
        if (used_add > peak_q) begin
          peak_q <= used_add;
        end
      end else if (free_commit) begin
        used_q     <= (used_q > fn_q) ? (used_q - fn_q) : '0;
        released_q <= rel_sum[FREED_W] ? '1 : rel_sum[FREED_W-1:0];
      end
    end
  end

  // valid flop per page, set on first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvld_q    <= '0;
      kvld_rd_q <= 1'b0;
    end else begin
      if (kind_we) begin
        kvld_q[waddr] <= 1'b1;
      end
      kvld_rd_q <= kvld_q[rd_addr];
    end
  end

  // result ports
  assign status_o       = status_q;
  assign start_page_o   = PAGE_W'(start_q);
  assign run_pages_o    = CNT_W'(count_q);
  assign in_use_pages_o = CNT_W'(used_q);
  assign peak_in_use_o  = CNT_W'(peak_q);
  assign freed_total_o  = released_q;
  assign tag_in_use_o   = CNT_W'(tag_pages_q[tag_q]);

endmodule

[rtl/core/first_fit_page_allocator.sv]
// channel  dir  ports                                    transaction taken when
// request  in   start, busy, op_i .. free_start_i        start high, busy low
// result   out  done_o, status_o .. tag_in_use_o         done_o high (one cycle)
// config   in   cfg_valid_i, cfg_ready_o, cfg_data_i     cfg_valid_i and cfg_ready_o high
//
// allocate: decode, then one scan step per page checked and one mark step per page granted;
// oversize fails at decode. free: decode, a lookup of the start page, then one clear step per
// page released; an error ends at the lookup. the page-map RAM reads or writes one page per cycle.
// reset clears the counters and sets the pool to 256 pages; per-page valid flops
// make the whole map read as free at once, so there is no clearing pass.
// done_o cannot be held off; busy drops in the done_o cycle for the next request.

`include "first_fit_page_allocator_macros.svh"

module first_fit_page_allocator import ffpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op_i,
  input  logic [BYTES_W-1:0]  request_bytes_i,
  input  logic [TAG_W-1:0]    owner_tag_i,
  input  logic [PAGE_W-1:0]   free_start_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [PAGE_W-1:0]   start_page_o,
  output logic [CNT_W-1:0]    run_pages_o,
  output logic [CNT_W-1:0]    in_use_pages_o,
  output logic [CNT_W-1:0]    peak_in_use_o,
  output logic [FREED_W-1:0]  freed_total_o,
  output logic [CNT_W-1:0]    tag_in_use_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [POOL_W-1:0]   cfg_data_i
);

  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  // pool size register is always writable
  assign cfg_ready_o = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  ffpa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .request_bytes_i(request_bytes_i),
    .owner_tag_i    (owner_tag_i),
    .free_start_i   (free_start_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status_o),
    .start_page_o   (start_page_o),
    .run_pages_o    (run_pages_o),
    .in_use_pages_o (in_use_pages_o),
    .peak_in_use_o  (peak_in_use_o),
    .freed_total_o  (freed_total_o),
    .tag_in_use_o   (tag_in_use_o)
  );

  // checks
  `FFPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `FFPA_ASSERT_NOW(a_err_no_pages, done_o && (status_o != ST_OK), run_pages_o == '0, "error result reports pages")
  `FFPA_ASSERT_NOW(a_no_run_start, done_o && (status_o == ST_NO_RUN), start_page_o == '0, "failed allocate reports a start page")
  `FFPA_ASSERT_NOW(a_peak_bound, done_o, in_use_pages_o <= peak_in_use_o, "in-use count above peak")

endmodule
